[rtl/core/bmpw_pkg.sv]
// ----------------------------------------------------------------------------
// bmpw_pkg
// Shared constants and the header byte table for the BMP stream writer.
// ----------------------------------------------------------------------------
package bmpw_pkg;

	localparam int DIM_BITS_DEFAULT = 12;
	localparam int WIDTH_RESET      = 320;
	localparam int HEIGHT_RESET     = 240;

	// Byte positions within one item's byte sequence.
	localparam logic [5:0] IDX_HDR_FIRST = 6'd0;
	localparam logic [5:0] IDX_PIX_BLUE  = 6'd54;
	localparam logic [5:0] IDX_PIX_GREEN = 6'd55;
	localparam logic [5:0] IDX_PIX_RED   = 6'd56;

	localparam logic [31:0] HDR_BYTES = 32'd54;
	localparam logic [31:0] INFO_SIZE = 32'd40;
	localparam logic [31:0] PPM       = 32'd2835;
	localparam logic [31:0] PLANES    = 32'd1;
	localparam logic [31:0] BPP       = 32'd24;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	// Every four-byte field of the header starts at an offset of 2 modulo 4, and the
	// planes and bit depth halves share one such word, so the byte lane inside a
	// field follows from the low index bits. The signature bytes sit in the upper
	// lanes of a word that starts at offset -2.
	function automatic logic [7:0] hdr_byte(
		input logic [5:0]  idx,
		input logic [31:0] file_size,
		input logic [31:0] img_w,
		input logic [31:0] img_h,
		input logic [31:0] img_size
	);
		logic [31:0] word;
		logic [1:0]  lane;
		lane = idx[1:0] ^ 2'b10;
		unique case (idx)
			6'd0, 6'd1:                word = {8'h4D, 8'h42, 16'h0000};
			6'd2, 6'd3, 6'd4, 6'd5:    word = file_size;
			6'd10, 6'd11, 6'd12, 6'd13: word = HDR_BYTES;
			6'd14, 6'd15, 6'd16, 6'd17: word = INFO_SIZE;
			6'd18, 6'd19, 6'd20, 6'd21: word = img_w;
			6'd22, 6'd23, 6'd24, 6'd25: word = img_h;
			6'd26, 6'd27, 6'd28, 6'd29: word = {BPP[15:0], PLANES[15:0]};
			6'd34, 6'd35, 6'd36, 6'd37: word = img_size;
			6'd38, 6'd39, 6'd40, 6'd41: word = PPM;
			6'd42, 6'd43, 6'd44, 6'd45: word = PPM;
			default:                   word = 32'd0;
		endcase
		return word[{lane, 3'b000} +: 8];
	endfunction

endpackage

[rtl/core/bmp_rgb565_stream_writer.sv]
// ----------------------------------------------------------------------------
// bmp_rgb565_stream_writer
// Turns RGB565 pixels into the byte stream of a 24-bit BMP file.
// ----------------------------------------------------------------------------
// A taken item is held in the item registers, and its bytes then pass through
// a single output register, one byte per cycle while the master side is ready:
// 3 per pixel, plus 0 to 3 of row padding and 54 for the file header.
// A new pixel is taken in the cycle that the previous item's last byte is issued.
// Reset (arst_n low) clears all counters and restores 320 x 240.
module bmp_rgb565_stream_writer
	import bmpw_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,   // pixel_color
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // out_byte
	output logic                m_tlast,   // last_of_run
	output logic [1:0]          m_tuser,   // end_of_image, error
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [DIM_BITS-1:0] cfg_wdata
);

	localparam int RB_BITS   = DIM_BITS + 2;
	localparam int PROD_BITS = RB_BITS + DIM_BITS;

	logic [DIM_BITS-1:0] width_q, height_q;
	logic [DIM_BITS-1:0] col_q, row_q;
	logic                hdr_sent_q;

	logic                busy_q, err_q, eoi_q;
	logic [5:0]          idx_q, end_idx_q;
	logic [15:0]         pix_s1;
	logic [31:0]         img_size_q;

	logic                m_valid_q, m_last_q, m_eoi_q, m_err_q;
	logic [7:0]          m_data_q;

	logic                emit, last_byte, done, accept;
	logic                dim_err, row_end, img_end;
	logic [RB_BITS-1:0]  row_bytes;
	logic [PROD_BITS-1:0] img_prod;
	logic [31:0]         file_size;
	logic [7:0]          byte_val;

	assign emit      = busy_q && (!m_valid_q || m_tready);
	assign last_byte = (idx_q == end_idx_q);
	assign done      = emit && last_byte;
	assign s_tready  = !busy_q || done;
	assign accept    = s_tvalid && s_tready;

	assign dim_err = (width_q == '0) || (height_q == '0);
	assign row_end = ({1'b0, col_q} + 1'b1) >= {1'b0, width_q};
	assign img_end = ({1'b0, row_q} + 1'b1) >= {1'b0, height_q};

	// Row length in bytes rounded up to a multiple of four.
	assign row_bytes = ({2'b00, width_q} + {1'b0, width_q, 1'b0} + RB_BITS'(3))
		& ~RB_BITS'(3);
	assign img_prod  = PROD_BITS'(row_bytes) * PROD_BITS'(height_q);
	assign file_size = img_size_q + HDR_BYTES;

	always_comb begin
		if (err_q) begin
			byte_val = 8'h00;
		end else if (idx_q < IDX_PIX_BLUE) begin
			byte_val = hdr_byte(idx_q, file_size, 32'(width_q), 32'(height_q), img_size_q);
		end else if (idx_q == IDX_PIX_BLUE) begin
			byte_val = {pix_s1[4:0], 3'b000};
		end else if (idx_q == IDX_PIX_GREEN) begin
			byte_val = {pix_s1[10:5], 2'b00};
		end else if (idx_q == IDX_PIX_RED) begin
			byte_val = {pix_s1[15:11], 3'b000};
		end else begin
			byte_val = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_BITS'(WIDTH_RESET);
			height_q <= DIM_BITS'(HEIGHT_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_wdata;
				REG_HEIGHT: height_q <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			hdr_sent_q <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			idx_q      <= '0;
			end_idx_q  <= '0;
			err_q      <= 1'b0;
			eoi_q      <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
			if (dim_err) begin
				err_q     <= 1'b1;
				eoi_q     <= 1'b0;
				idx_q     <= IDX_PIX_BLUE;
				end_idx_q <= IDX_PIX_BLUE;
			end else begin
				err_q     <= 1'b0;
				eoi_q     <= row_end && img_end;
				idx_q     <= hdr_sent_q ? IDX_PIX_BLUE : IDX_HDR_FIRST;
				end_idx_q <= IDX_PIX_RED + (row_end ? {4'b0000, width_q[1:0]} : 6'd0);
				hdr_sent_q <= !(row_end && img_end);
				if (row_end) begin
					col_q <= '0;
					row_q <= img_end ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= s_tdata;
			if (!hdr_sent_q) begin
				img_size_q <= 32'(img_prod);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q <= byte_val;
			m_last_q <= last_byte;
			m_eoi_q  <= last_byte && eoi_q;
			m_err_q  <= err_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = {m_err_q, m_eoi_q};

endmodule

[rtl/core/bmpw_chk.sv]
// ----------------------------------------------------------------------------
// bmpw_chk
// Port-level checks for the BMP stream writer, bound to the top level.
// ----------------------------------------------------------------------------
module bmpw_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [1:0] m_tuser
);

	// A stalled beat keeps its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled beat changed");

	// An error beat is a lone zero byte that closes its run and not the image.
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && (m_tdata == 8'h00))
		else $error("malformed error beat");

	// The end of the file is always the end of a run.
	a_eoi_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("end of image without tlast");

	// Every taken pixel is followed by a valid beat on the master side.
	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("no output after accepted pixel");

endmodule

bind bmp_rgb565_stream_writer bmpw_chk u_bmpw_chk (.*);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bmp_rgb565_stream_writer. RGB565 pixels go in on the
// slave stream and the BMP byte stream comes back on the master stream. Each
// pixel beat that is taken is run through a local model of the writer: header,
// pixel bytes, row padding and image end. The bytes it predicts, or those that a
// directed row gives, are queued and compared, field by field, against every
// beat that leaves the block. A short table of directed rows comes first, and
// then randomized image phases. Both stream sides see random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench
	import bmpw_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_PIXELS = 380;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       eoi;
		logic       err;
	} beat_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_PIXEL} row_kind_e;
	typedef enum logic [1:0] {KNOWN_NONE, KNOWN_BYTES, KNOWN_ERROR} known_e;

	typedef struct packed {
		row_kind_e   kind;
		logic [0:0]  reg_sel;
		logic [15:0] value;
		known_e      known;
		logic [23:0] bytes;   // first byte in the low bits
	} dir_row_t;

	localparam int DIR_ROWS = 28;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;   // pixel_color
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;           // out_byte
	logic        m_tlast;           // last_of_run
	logic [1:0]  m_tuser;           // end_of_image, error
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_WIDTH;
	logic [11:0] cfg_wdata = 12'd0;

	bmp_rgb565_stream_writer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Mirror of the writer's registers and counters.
	logic [11:0] img_w = 12'(WIDTH_RESET);
	logic [11:0] img_h = 12'(HEIGHT_RESET);
	logic [11:0] col_pos = 12'd0;
	logic [11:0] row_pos = 12'd0;
	logic        header_done = 1'b0;

	beat_t    pixel_beats[$];
	beat_t    bmp_bytes_q[$];
	beat_t    want;
	dir_row_t directed_rows [0:DIR_ROWS-1];

	int fail_count;
	int items_sent;
	int random_items;
	int beats_checked;
	int images_done;
	int zero_rejects;
	int cfg_writes;
	int burst_left;

	int rdy_mode;
	int rdy_left;
	int stall_left;

	function automatic logic [31:0] padded_row(input logic [11:0] w);
		return (32'(w) * 32'd3 + 32'd3) & ~32'd3;
	endfunction

	function automatic void put_le(input logic [31:0] v, input int nbytes);
		for (int i = 0; i < nbytes; i++)
			pixel_beats.push_back('{v[8*i +: 8], 1'b0, 1'b0, 1'b0});
	endfunction

	// Works out the bytes that one pixel beat causes and advances the mirror state.
	function automatic void bmp_predict_pixel(input logic [15:0] color);
		logic [31:0] row_len;
		logic [31:0] img_bytes;
		logic        end_img;
		beat_t       tail;
		pixel_beats.delete();
		end_img = 1'b0;
		if (img_w == 12'd0 || img_h == 12'd0) begin
			pixel_beats.push_back('{8'h00, 1'b1, 1'b0, 1'b1});
			zero_rejects++;
			return;
		end
		row_len = padded_row(img_w);
		if (!header_done) begin
			img_bytes = row_len * 32'(img_h);
			put_le(32'h0000_4D42, 2);
			put_le(HDR_BYTES + img_bytes, 4);
			put_le(32'd0, 4);
			put_le(HDR_BYTES, 4);
			put_le(INFO_SIZE, 4);
			put_le(32'(img_w), 4);
			put_le(32'(img_h), 4);
			put_le(PLANES, 2);
			put_le(BPP, 2);
			put_le(32'd0, 4);
			put_le(img_bytes, 4);
			put_le(PPM, 4);
			put_le(PPM, 4);
			put_le(32'd0, 4);
			put_le(32'd0, 4);
			header_done = 1'b1;
		end
		put_le({24'd0, color[4:0], 3'b000}, 1);
		put_le({24'd0, color[10:5], 2'b00}, 1);
		put_le({24'd0, color[15:11], 3'b000}, 1);
		if (32'(col_pos) + 32'd1 >= 32'(img_w)) begin
			put_le(32'd0, int'(row_len - 32'(img_w) * 32'd3));
			col_pos = 12'd0;
			if (32'(row_pos) + 32'd1 >= 32'(img_h)) begin
				end_img = 1'b1;
				row_pos = 12'd0;
				header_done = 1'b0;
				images_done++;
			end else begin
				row_pos = row_pos + 12'd1;
			end
		end else begin
			col_pos = col_pos + 12'd1;
		end
		tail = pixel_beats.pop_back();
		tail.last = 1'b1;
		tail.eoi = end_img;
		pixel_beats.push_back(tail);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (bmp_bytes_q.size() == 0) begin
				$display("%0t: beat with nothing expected, expected none, actual data %02h last %b user %b",
					$time, m_tdata, m_tlast, m_tuser);
				fail_count++;
			end else begin
				want = bmp_bytes_q.pop_front();
				check_field("out_byte", want.data, m_tdata);
				check_field("last_of_run", {7'd0, want.last}, {7'd0, m_tlast});
				check_field("end_of_image", {7'd0, want.eoi}, {7'd0, m_tuser[0]});
				check_field("error", {7'd0, want.err}, {7'd0, m_tuser[1]});
				beats_checked++;
			end
		end
	end

	// Receiver: switches between always ready, coin flips, stall runs and rare stalls.
	always @(negedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode = $urandom_range(0, 3);
			rdy_left = $urandom_range(20, 120);
		end
		rdy_left--;
		case (rdy_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: begin
				if (stall_left == 0) begin
					stall_left = $urandom_range(1, 8);
					m_tready <= ~m_tready;
				end
				stall_left--;
			end
			default: m_tready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// All tasks start and end at a falling edge.
	task automatic send_pixel(input logic [15:0] color, input known_e known,
			input logic [23:0] known_bytes);
		s_tvalid = 1'b1;
		s_tdata = color;
		do @(posedge clk); while (!s_tready);
		bmp_predict_pixel(color);
		case (known)
			KNOWN_BYTES: begin
				for (int i = 0; i < 3; i++)
					bmp_bytes_q.push_back('{known_bytes[8*i +: 8], i == 2, 1'b0, 1'b0});
			end
			KNOWN_ERROR: bmp_bytes_q.push_back('{8'h00, 1'b1, 1'b0, 1'b1});
			default: begin
				foreach (pixel_beats[i])
					bmp_bytes_q.push_back(pixel_beats[i]);
			end
		endcase
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_stream(input int extra);
		s_tvalid = 1'b0;
		while (bmp_bytes_q.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] sel, input logic [11:0] value);
		cfg_we = 1'b1;
		cfg_index = sel;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (sel == REG_WIDTH)
			img_w = value;
		else
			img_h = value;
		cfg_writes++;
	endtask

	task automatic send_random();
		int gap;
		logic [15:0] color;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
				: $urandom_range(1, 12);
		end
		burst_left--;
		// Now and then hold off until the block has emptied.
		if ($urandom_range(0, 49) == 0)
			drain_stream(0);
		case ($urandom_range(0, 19))
			0: color = 16'h0000;
			1: color = 16'hFFFF;
			2: color = 16'h001F;
			3: color = 16'h07E0;
			4: color = 16'hF800;
			default: color = 16'($urandom);
		endcase
		send_pixel(color, KNOWN_NONE, 24'd0);
		random_items++;
	endtask

	initial begin : stimulus
		int w;
		int h;
		int n;
		int pick;
		directed_rows = '{
			'{ROW_PIXEL, REG_WIDTH,  16'h0000, KNOWN_NONE,  24'h000000},  // 320 x 240 header
			'{ROW_PIXEL, REG_WIDTH,  16'hFFFF, KNOWN_BYTES, 24'hF8FCF8},
			'{ROW_PIXEL, REG_WIDTH,  16'h001F, KNOWN_BYTES, 24'h0000F8},
			'{ROW_PIXEL, REG_WIDTH,  16'h07E0, KNOWN_BYTES, 24'h00FC00},
			'{ROW_PIXEL, REG_WIDTH,  16'hF800, KNOWN_BYTES, 24'hF80000},
			'{ROW_WRITE, REG_WIDTH,  16'd0,    KNOWN_NONE,  24'h000000},
			'{ROW_PIXEL, REG_WIDTH,  16'h1234, KNOWN_ERROR, 24'h000000},
			'{ROW_WRITE, REG_WIDTH,  16'd4095, KNOWN_NONE,  24'h000000},
			'{ROW_WRITE, REG_HEIGHT, 16'd0,    KNOWN_NONE,  24'h000000},
			'{ROW_PIXEL, REG_WIDTH,  16'hFFFF, KNOWN_ERROR, 24'h000000},
			// Shrinking both sizes mid-image ends the open image on the next pixel.
			'{ROW_WRITE, REG_WIDTH,  16'd1,    KNOWN_NONE,  24'h000000},
			'{ROW_WRITE, REG_HEIGHT, 16'd1,    KNOWN_NONE,  24'h000000},
			'{ROW_PIXEL, REG_WIDTH,  16'h5A5A, KNOWN_NONE,  24'h000000},
			'{ROW_PIXEL, REG_WIDTH,  16'h0001, KNOWN_NONE,  24'h000000},
			'{ROW_WRITE, REG_WIDTH,  16'd4095, KNOWN_NONE,  24'h000000},
			'{ROW_WRITE, REG_HEIGHT, 16'd4095, KNOWN_NONE,  24'h000000},
			'{ROW_PIXEL, REG_WIDTH,  16'h8000, KNOWN_NONE,  24'h000000},
			'{ROW_PIXEL, REG_WIDTH,  16'h7FFF, KNOWN_BYTES, 24'h78FCF8},
			'{ROW_WRITE, REG_WIDTH,  16'd3,    KNOWN_NONE,  24'h000000},
			'{ROW_WRITE, REG_HEIGHT, 16'd2,    KNOWN_NONE,  24'h000000},
			'{ROW_PIXEL, REG_WIDTH,  16'h0842, KNOWN_NONE,  24'h000000},
			'{ROW_PIXEL, REG_WIDTH,  16'h1111, KNOWN_NONE,  24'h000000},
			'{ROW_PIXEL, REG_WIDTH,  16'h2222, KNOWN_NONE,  24'h000000},
			'{ROW_PIXEL, REG_WIDTH,  16'h3333, KNOWN_NONE,  24'h000000},
			'{ROW_WRITE, REG_WIDTH,  16'd2,    KNOWN_NONE,  24'h000000},
			'{ROW_WRITE, REG_HEIGHT, 16'd1,    KNOWN_NONE,  24'h000000},
			'{ROW_PIXEL, REG_WIDTH,  16'h4444, KNOWN_NONE,  24'h000000},
			'{ROW_PIXEL, REG_WIDTH,  16'hFFFF, KNOWN_NONE,  24'h000000}
		};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				drain_stream(3);
				write_reg(directed_rows[i].reg_sel, directed_rows[i].value[11:0]);
			end else begin
				send_pixel(directed_rows[i].value, directed_rows[i].known,
					directed_rows[i].bytes);
			end
		end

		while (random_items < RANDOM_PIXELS) begin
			drain_stream(3);
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				if ($urandom_range(0, 1) == 1)
					write_reg(REG_WIDTH, 12'd0);
				else
					write_reg(REG_HEIGHT, 12'd0);
				n = $urandom_range(1, 4);
			end else if (pick < 16) begin
				write_reg(REG_WIDTH, ($urandom_range(0, 3) == 0) ? 12'd4095
					: 12'($urandom_range(64, 4095)));
				write_reg(REG_HEIGHT, 12'($urandom_range(1, 4095)));
				n = $urandom_range(1, 6);
			end else begin
				w = $urandom_range(1, 6);
				h = $urandom_range(1, 4);
				if (32'(img_w) != w || $urandom_range(0, 3) == 0)
					write_reg(REG_WIDTH, 12'(w));
				if (32'(img_h) != h || $urandom_range(0, 3) == 0)
					write_reg(REG_HEIGHT, 12'(h));
				if (pick < 80) begin
					// Close any image left open, then send whole images.
					while (header_done)
						send_random();
					n = w * h * $urandom_range(1, 3);
				end else begin
					n = $urandom_range(1, 15);
				end
			end
			repeat (n) send_random();
		end

		drain_stream(0);
		repeat (20) @(posedge clk);
		$display("Sent %0d pixel beats (%0d random), closing %0d images; %0d zero-size rejects.",
			items_sent, random_items, images_done, zero_rejects);
		$display("Made %0d register writes and checked %0d output bytes; %0d mismatches.",
			cfg_writes, beats_checked, fail_count);
		if (fail_count == 0 && bmp_bytes_q.size() == 0)
			$display("** bmp_rgb565_stream_writer: PASSED **");
		else
			$display("** bmp_rgb565_stream_writer: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d bytes still expected.", bmp_bytes_q.size());
		$display("** bmp_rgb565_stream_writer: FAILED **");
		$finish;
	end

endmodule
